FILE: rtl/gsab_pkg.sv
// Shared types, constants and exp table builder for the splat blender.
`default_nettype none
package gsab_pkg;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [15:0] ALPHA_LIMIT = 16'd64881;
    localparam logic [15:0] ALPHA_MIN   = 16'd258;
    localparam logic [16:0] T_FLOOR     = 17'd6;
    localparam logic [15:0] OUT_MAX     = 16'd32768;
    localparam longint unsigned EM1_Q31 = 64'd790015084;

    typedef struct packed {
        logic [15:0] opacity;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
        logic [11:0] px;
        logic [11:0] py;
    } pass_t;

    typedef struct packed {
        logic [15:0] alpha;
        logic        blend_en;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
        logic [11:0] px;
        logic [11:0] py;
    } item_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_OUT
    } back_state_t;

    function automatic longint unsigned div_small(input longint unsigned t,
                                                  input int unsigned n);
        case (n)
            2:  return t / 64'd2;
            3:  return t / 64'd3;
            4:  return t / 64'd4;
            5:  return t / 64'd5;
            6:  return t / 64'd6;
            7:  return t / 64'd7;
            8:  return t / 64'd8;
            9:  return t / 64'd9;
            10: return t / 64'd10;
            11: return t / 64'd11;
            12: return t / 64'd12;
            13: return t / 64'd13;
            14: return t / 64'd14;
            15: return t / 64'd15;
            16: return t / 64'd16;
            17: return t / 64'd17;
            18: return t / 64'd18;
            19: return t / 64'd19;
            20: return t / 64'd20;
            default: return t;
        endcase
    endfunction

    function automatic longint unsigned exp_frac_q31(input longint unsigned f);
        longint acc;
        longint unsigned term;
        acc  = 64'sd2147483648;
        term = 64'd2147483648;
        for (int unsigned n = 1; n <= 20; n++) begin
            term = div_small((term * f) >> 31, n);
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return longint'(acc);
    endfunction

    function automatic logic [15:0] exp_entry(input longint unsigned x);
        longint unsigned ip;
        longint unsigned p;
        longint unsigned r;
        ip = x >> 31;
        p  = 64'd2147483648;
        for (longint unsigned i = 0; i < 16; i++) begin
            if (i < ip) begin
                p = (p * EM1_Q31 + 64'd1073741824) >> 31;
            end
        end
        r = (p * exp_frac_q31(x & 64'h7FFF_FFFF) + 64'd1073741824) >> 31;
        r = (r + 64'd16384) >> 15;
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gsab_front.sv
// Front pipeline: quadratic exponent, exp lookup and alpha per splat.
`default_nettype none
module gsab_front #(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [11:0]           pixel_x,
    input  wire logic [11:0]           pixel_y,
    input  wire logic signed [20:0]    center_x,
    input  wire logic signed [20:0]    center_y,
    input  wire logic signed [31:0]    conic_xx,
    input  wire logic signed [31:0]    conic_xy,
    input  wire logic signed [31:0]    conic_yy,
    input  wire logic [15:0]           opacity,
    input  wire logic [15:0]           color_red,
    input  wire logic [15:0]           color_green,
    input  wire logic [15:0]           color_blue,
    input  wire logic                  last_splat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gsab_pkg::item_t            out_item
);
    import gsab_pkg::*;

    localparam int IW = $clog2(EXP_TABLE_ENTRIES);

    logic [15:0] rom [EXP_TABLE_ENTRIES];

    for (genvar k = 0; k < EXP_TABLE_ENTRIES; k++) begin : g_rom
        localparam longint unsigned XK =
            ((64'(2 * k + 1) * 64'd4) << 31) / 64'(EXP_TABLE_ENTRIES);
        localparam logic [15:0] WK = exp_entry(XK);
        assign rom[k] = WK;
    end

    logic [8:1] v_reg;
    logic       en;
    pass_t      p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;

    logic [20:0] ax_reg, ay_reg;
    logic        sxy1_reg, sxy2_reg;
    logic [31:0] cxx1_reg, cxy1_reg, cyy1_reg, cxx2_reg, cxy2_reg, cyy2_reg;
    logic [41:0] pxx_reg, pyy_reg, pxy_reg;
    logic [49:0] hxx_reg, hyy_reg, hxy_reg;
    logic [31:0] lxx_reg, lyy_reg, lxy_reg;
    logic        nxx_reg, nyy_reg, nxy_reg;
    logic signed [52:0] txx_reg, tyy_reg, txy_reg;
    logic [19:0] q_reg;
    logic        in5_reg, in6_reg, in7_reg;
    logic [IW-1:0] idx_reg;
    logic [15:0] w_reg;
    item_t       item_reg;

    logic signed [22:0] dx, dy;
    logic [31:0] mxx, myy, mxy;
    logic [55:0] fxx, fyy, fxy;
    logic [50:0] sxx, syy, sxy;
    logic signed [54:0] q;
    logic [39:0] iprod;
    logic [31:0] aprod;
    logic [15:0] alpha;

    assign en        = !v_reg[8] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[8];
    assign out_item  = item_reg;

    always_comb begin
        dx  = $signed({3'b0, pixel_x, 8'h80}) - 23'(center_x);
        dy  = $signed({3'b0, pixel_y, 8'h80}) - 23'(center_y);
        mxx = cxx2_reg[31] ? (~cxx2_reg + 32'd1) : cxx2_reg;
        myy = cyy2_reg[31] ? (~cyy2_reg + 32'd1) : cyy2_reg;
        mxy = cxy2_reg[31] ? (~cxy2_reg + 32'd1) : cxy2_reg;
        fxx = 56'(pxx_reg[23:0]) * 56'(mxx);
        fyy = 56'(pyy_reg[23:0]) * 56'(myy);
        fxy = 56'(pxy_reg[23:0]) * 56'(mxy);
        sxx = 51'(hxx_reg) + 51'(lxx_reg);
        syy = 51'(hyy_reg) + 51'(lyy_reg);
        sxy = 51'(hxy_reg) + 51'(lxy_reg);
        q   = 55'(txx_reg) + 55'(tyy_reg) + (55'(txy_reg) <<< 1);
        iprod = 40'(q_reg) * 40'(EXP_TABLE_ENTRIES);
        aprod = 32'(p7_reg.opacity) * 32'(w_reg) + 32'h8000;
        alpha = (aprod[31:16] > ALPHA_LIMIT) ? ALPHA_LIMIT : aprod[31:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[7:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg   <= dx[22] ? 21'(-dx) : dx[20:0];
            ay_reg   <= dy[22] ? 21'(-dy) : dy[20:0];
            sxy1_reg <= dx[22] ^ dy[22];
            cxx1_reg <= conic_xx;
            cxy1_reg <= conic_xy;
            cyy1_reg <= conic_yy;
            p1_reg   <= '{opacity, color_red, color_green, color_blue, last_splat,
                          pixel_x, pixel_y};

            pxx_reg  <= 42'(ax_reg) * 42'(ax_reg);
            pyy_reg  <= 42'(ay_reg) * 42'(ay_reg);
            pxy_reg  <= 42'(ax_reg) * 42'(ay_reg);
            sxy2_reg <= sxy1_reg;
            cxx2_reg <= cxx1_reg;
            cxy2_reg <= cxy1_reg;
            cyy2_reg <= cyy1_reg;
            p2_reg   <= p1_reg;

            hxx_reg  <= 50'(pxx_reg[41:24]) * 50'(mxx);
            hyy_reg  <= 50'(pyy_reg[41:24]) * 50'(myy);
            hxy_reg  <= 50'(pxy_reg[41:24]) * 50'(mxy);
            lxx_reg  <= fxx[55:24];
            lyy_reg  <= fyy[55:24];
            lxy_reg  <= fxy[55:24];
            nxx_reg  <= cxx2_reg[31];
            nyy_reg  <= cyy2_reg[31];
            nxy_reg  <= sxy2_reg ^ cxy2_reg[31];
            p3_reg   <= p2_reg;

            txx_reg  <= nxx_reg ? -$signed({2'b0, sxx}) : $signed({2'b0, sxx});
            tyy_reg  <= nyy_reg ? -$signed({2'b0, syy}) : $signed({2'b0, syy});
            txy_reg  <= nxy_reg ? -$signed({2'b0, sxy}) : $signed({2'b0, sxy});
            p4_reg   <= p3_reg;

            q_reg    <= q[19:0];
            in5_reg  <= !q[54] && (q[53:20] == '0);
            p5_reg   <= p4_reg;

            idx_reg  <= iprod[20 +: IW];
            in6_reg  <= in5_reg;
            p6_reg   <= p5_reg;

            w_reg    <= rom[idx_reg];
            in7_reg  <= in6_reg;
            p7_reg   <= p6_reg;

            item_reg <= '{alpha, in7_reg && (alpha >= ALPHA_MIN), p7_reg.red,
                          p7_reg.green, p7_reg.blue, p7_reg.last, p7_reg.px,
                          p7_reg.py};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gsab_queue.sv
// Short queue between the front pipeline and the blending back end.
`default_nettype none
module gsab_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire gsab_pkg::item_t wdata,
    output logic                 full,
    input  wire logic            pop,
    output logic                 nonempty,
    output gsab_pkg::item_t      rdata
);
    import gsab_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    item_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;

    assign full     = (cnt_reg == (AW + 1)'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gsab_back.sv
// Back end: transmittance update, colour accumulation and pixel output.
`default_nettype none
module gsab_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_nonempty,
    input  wire gsab_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [11:0]          m_out_x,
    output logic [11:0]          m_out_y,
    output logic [15:0]          m_pixel_red,
    output logic [15:0]          m_pixel_green,
    output logic [15:0]          m_pixel_blue
);
    import gsab_pkg::*;

    back_state_t state_reg, state_next;
    item_t       cur_reg;
    logic [16:0] t_reg, ta_reg, tn_reg;
    logic        sat_reg, act_reg;
    logic [31:0] sr_reg, sg_reg, sb_reg;
    logic        m_valid_reg;
    logic [11:0] ox_reg, oy_reg;
    logic [15:0] or_reg, og_reg, ob_reg;

    logic [33:0] ta_prod, tn_prod;
    logic [32:0] ir, ig, ib;
    logic [32:0] nr, ng, nb;

    assign m_valid       = m_valid_reg;
    assign m_out_x       = ox_reg;
    assign m_out_y       = oy_reg;
    assign m_pixel_red   = or_reg;
    assign m_pixel_green = og_reg;
    assign m_pixel_blue  = ob_reg;

    function automatic logic [15:0] to_out(input logic [31:0] s);
        logic [32:0] v;
        v = (33'(s) + 33'd1) >> 1;
        return (v > 33'(OUT_MAX)) ? OUT_MAX : v[15:0];
    endfunction

    always_comb begin
        ta_prod = 34'(t_reg) * 34'(cur_reg.alpha) + 34'h8000;
        tn_prod = 34'(t_reg) * 34'(ONE_Q16 - 17'(cur_reg.alpha)) + 34'h8000;
        ir = 33'(sr_reg) + 33'((34'(ta_reg) * 34'(cur_reg.red) + 34'h2000) >> 14);
        ig = 33'(sg_reg) + 33'((34'(ta_reg) * 34'(cur_reg.green) + 34'h2000) >> 14);
        ib = 33'(sb_reg) + 33'((34'(ta_reg) * 34'(cur_reg.blue) + 34'h2000) >> 14);
        nr = ir[32] ? 33'h0_FFFF_FFFF : ir;
        ng = ig[32] ? 33'h0_FFFF_FFFF : ig;
        nb = ib[32] ? 33'h0_FFFF_FFFF : ib;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_nonempty && (!q_item.last || !m_valid_reg)) begin
                    q_pop      = 1'b1;
                    state_next = B_MUL;
                end
            end
            B_MUL:   state_next = B_ACC;
            B_ACC:   state_next = cur_reg.last ? B_OUT : B_IDLE;
            B_OUT:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg       <= ONE_Q16;
            sat_reg     <= 1'b0;
            sr_reg      <= '0;
            sg_reg      <= '0;
            sb_reg      <= '0;
            m_valid_reg <= 1'b0;
            act_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_MUL: begin
                    act_reg <= cur_reg.blend_en && !sat_reg;
                end
                B_ACC: begin
                    if (act_reg) begin
                        sr_reg  <= nr[31:0];
                        sg_reg  <= ng[31:0];
                        sb_reg  <= nb[31:0];
                        t_reg   <= tn_reg;
                        sat_reg <= (tn_reg <= T_FLOOR);
                    end
                end
                B_OUT: begin
                    m_valid_reg <= 1'b1;
                    t_reg       <= ONE_Q16;
                    sat_reg     <= 1'b0;
                    sr_reg      <= '0;
                    sg_reg      <= '0;
                    sb_reg      <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        if (state_reg == B_MUL) begin
            ta_reg <= ta_prod[32:16];
            tn_reg <= tn_prod[32:16];
        end
        if (state_reg == B_OUT) begin
            ox_reg <= cur_reg.px;
            oy_reg <= cur_reg.py;
            or_reg <= to_out(sr_reg);
            og_reg <= to_out(sg_reg);
            ob_reg <= to_out(sb_reg);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gaussian_splat_alpha_blend.sv
// Gaussian splat front-to-back alpha blender, one pixel result per sorted list.
//
// Input channel s_*: one depth-sorted splat per transfer, s_last_splat on the
// final splat of a pixel; a pixel with no splats is sent as one item with zero
// opacity. Result channel m_*: one transfer per pixel, carrying the coordinates
// of its last item and the blended colour in Q1.15, clamped to one.
// An eight-stage front pipeline forms the exponent, the exp weight and alpha,
// taking one splat per cycle into a four-entry queue while the queue is not
// full. The back end steps each splat through B_IDLE (pop), B_MUL
// (transmittance multiply) and B_ACC (accumulate), plus B_OUT on the last
// splat to load the output register, and takes no new splat until it is
// through with the last, as the transmittance update is serial.
// Reset (aresetn low, synchronous) empties the pipeline and queue and returns
// the sums to zero and transmittance to one; the exp table is constant logic.
// When the receiver stalls, the finished pixel holds in the output register;
// the back end keeps blending the next pixel until it reaches that pixel's
// last splat, and the queue then backs up into s_ready.
`default_nettype none
module gaussian_splat_alpha_blend #(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [11:0]         s_pixel_x,
    input  wire logic [11:0]         s_pixel_y,
    input  wire logic signed [20:0]  s_center_x,
    input  wire logic signed [20:0]  s_center_y,
    input  wire logic signed [31:0]  s_conic_xx,
    input  wire logic signed [31:0]  s_conic_xy,
    input  wire logic signed [31:0]  s_conic_yy,
    input  wire logic [15:0]         s_opacity,
    input  wire logic [15:0]         s_color_red,
    input  wire logic [15:0]         s_color_green,
    input  wire logic [15:0]         s_color_blue,
    input  wire logic                s_last_splat,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [11:0]              m_out_x,
    output logic [11:0]              m_out_y,
    output logic [15:0]              m_pixel_red,
    output logic [15:0]              m_pixel_green,
    output logic [15:0]              m_pixel_blue
);
    import gsab_pkg::*;

    logic  fr_valid, q_full, q_nonempty, q_pop, fr_push;
    item_t fr_item, q_item;

    assign fr_push = fr_valid && !q_full;

    gsab_front #(
        .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .pixel_x     (s_pixel_x),
        .pixel_y     (s_pixel_y),
        .center_x    (s_center_x),
        .center_y    (s_center_y),
        .conic_xx    (s_conic_xx),
        .conic_xy    (s_conic_xy),
        .conic_yy    (s_conic_yy),
        .opacity     (s_opacity),
        .color_red   (s_color_red),
        .color_green (s_color_green),
        .color_blue  (s_color_blue),
        .last_splat  (s_last_splat),
        .out_valid   (fr_valid),
        .out_ready   (!q_full),
        .out_item    (fr_item)
    );

    gsab_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fr_push),
        .wdata    (fr_item),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .rdata    (q_item)
    );

    gsab_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_nonempty    (q_nonempty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_pixel_red   (m_pixel_red),
        .m_pixel_green (m_pixel_green),
        .m_pixel_blue  (m_pixel_blue)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_nonempty) else $error("pop from empty queue");
    a_alpha_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_push |-> (fr_item.alpha <= ALPHA_LIMIT)) else $error("alpha above limit");
    a_faint_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (fr_push && fr_item.blend_en) |-> (fr_item.alpha >= ALPHA_MIN))
        else $error("faint splat marked for blending");
    a_last_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.last) |-> !m_valid) else $error("last splat popped while output full");
`endif

endmodule
`default_nettype wire

FILE: verif/gaussian_splat_alpha_blend_test.sv
// Self-checking testbench for the Gaussian splat front-to-back alpha blender.
`default_nettype none
module gaussian_splat_alpha_blend_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TABLE_SIZE  = 256;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 60;
    localparam longint unsigned RECIP_E_Q31 = 64'd790015084;

    typedef struct {
        logic [11:0]        px;
        logic [11:0]        py;
        logic signed [20:0] cx;
        logic signed [20:0] cy;
        logic signed [31:0] cxx;
        logic signed [31:0] cxy;
        logic signed [31:0] cyy;
        logic [15:0]        opacity;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic               last;
    } splat_t;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [11:0]        s_pixel_x;
    logic [11:0]        s_pixel_y;
    logic signed [20:0] s_center_x;
    logic signed [20:0] s_center_y;
    logic signed [31:0] s_conic_xx;
    logic signed [31:0] s_conic_xy;
    logic signed [31:0] s_conic_yy;
    logic [15:0]        s_opacity;
    logic [15:0]        s_color_red;
    logic [15:0]        s_color_green;
    logic [15:0]        s_color_blue;
    logic               s_last_splat;
    logic               m_valid;
    logic               m_ready;
    logic [11:0]        m_out_x;
    logic [11:0]        m_out_y;
    logic [15:0]        m_pixel_red;
    logic [15:0]        m_pixel_green;
    logic [15:0]        m_pixel_blue;

    gaussian_splat_alpha_blend u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_conic_xx    (s_conic_xx),
        .s_conic_xy    (s_conic_xy),
        .s_conic_yy    (s_conic_yy),
        .s_opacity     (s_opacity),
        .s_color_red   (s_color_red),
        .s_color_green (s_color_green),
        .s_color_blue  (s_color_blue),
        .s_last_splat  (s_last_splat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_pixel_red   (m_pixel_red),
        .m_pixel_green (m_pixel_green),
        .m_pixel_blue  (m_pixel_blue)
    );

    logic [15:0]     weight_lut [TABLE_SIZE];
    longint unsigned sum_r, sum_g, sum_b;
    longint unsigned trans;
    bit              trans_floor_hit;
    pixel_t          pending_pixels [$];
    int              mismatches;
    int              splats_sent;
    int              idle_pct;
    int              hold_request;
    int              cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // exp(-f), f in Q31 within [0,1), by alternating series
    function automatic longint unsigned exp_fraction(longint unsigned f);
        longint          total;
        longint unsigned step;
        total = 64'sd2147483648;
        step  = 64'd2147483648;
        for (int n = 1; n <= 20; n++) begin
            step = ((step * f) >> 31) / n;
            if (n % 2 == 1) begin
                total -= longint'(step);
            end else begin
                total += longint'(step);
            end
        end
        if (total < 0) begin
            total = 0;
        end
        return longint'(total);
    endfunction

    function automatic logic [15:0] weight_at(int k);
        longint unsigned arg, whole, scale, r;
        arg   = ((longint'(2 * k + 1) * 4) << 31) / TABLE_SIZE;
        whole = arg >> 31;
        scale = 64'd2147483648;
        for (longint unsigned i = 0; i < whole && i < 16; i++) begin
            scale = (scale * RECIP_E_Q31 + 64'd1073741824) >> 31;
        end
        r = (scale * exp_fraction(arg & 64'h7FFF_FFFF) + 64'd1073741824) >> 31;
        r = (r + 64'd16384) >> 15;
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        return r[15:0];
    endfunction

    function automatic longint conic_term(longint unsigned mag, longint coef, bit neg);
        longint unsigned cmag, m;
        cmag = (coef < 0) ? longint'(-coef) : longint'(coef);
        m    = (mag >> 24) * cmag + (((mag & 64'hFF_FFFF) * cmag) >> 24);
        if (coef < 0) begin
            neg = !neg;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned sat_add(longint unsigned s, longint unsigned a);
        longint unsigned t;
        t = s + a;
        return (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
    endfunction

    function automatic logic [15:0] clamp_channel(longint unsigned s);
        longint unsigned v;
        v = (s + 1) >> 1;
        return (v > 32768) ? 16'd32768 : v[15:0];
    endfunction

    function automatic void clear_pixel();
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        trans = 65536;
        trans_floor_hit = 1'b0;
    endfunction

    function automatic void blend_splat(splat_t sp);
        longint          dx, dy, q;
        longint unsigned ax, ay, idx, a, ta;
        dx = longint'({sp.px, 8'd128}) - longint'(sp.cx);
        dy = longint'({sp.py, 8'd128}) - longint'(sp.cy);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        q  = conic_term(ax * ax, longint'(sp.cxx), 1'b0)
           + conic_term(ay * ay, longint'(sp.cyy), 1'b0)
           + 2 * conic_term(ax * ay, longint'(sp.cxy), (dx < 0) != (dy < 0));
        if (q < 0 || q >= 1048576) begin
            return;
        end
        idx = (longint'(q) * TABLE_SIZE) >> 20;
        if (idx >= TABLE_SIZE) begin
            idx = TABLE_SIZE - 1;
        end
        a = (longint'(sp.opacity) * weight_lut[idx] + 64'h8000) >> 16;
        if (a > 64881) begin
            a = 64881;
        end
        if (255 * a < 65536) begin
            return;
        end
        ta    = (trans * a + 64'h8000) >> 16;
        sum_r = sat_add(sum_r, (ta * sp.red + 64'h2000) >> 14);
        sum_g = sat_add(sum_g, (ta * sp.green + 64'h2000) >> 14);
        sum_b = sat_add(sum_b, (ta * sp.blue + 64'h2000) >> 14);
        trans = (trans * (65536 - a) + 64'h8000) >> 16;
        if (trans <= 6) begin
            trans_floor_hit = 1'b1;
        end
    endfunction

    function automatic void predict_pixel(splat_t sp);
        pixel_t p;
        if (!trans_floor_hit) begin
            blend_splat(sp);
        end
        if (sp.last) begin
            p.x     = sp.px;
            p.y     = sp.py;
            p.red   = clamp_channel(sum_r);
            p.green = clamp_channel(sum_g);
            p.blue  = clamp_channel(sum_b);
            pending_pixels.insert(pending_pixels.size(), p);
            clear_pixel();
        end
    endfunction

    task automatic send_splat(splat_t sp);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_x     <= sp.px;
        s_pixel_y     <= sp.py;
        s_center_x    <= sp.cx;
        s_center_y    <= sp.cy;
        s_conic_xx    <= sp.cxx;
        s_conic_xy    <= sp.cxy;
        s_conic_yy    <= sp.cyy;
        s_opacity     <= sp.opacity;
        s_color_red   <= sp.red;
        s_color_green <= sp.green;
        s_color_blue  <= sp.blue;
        s_last_splat  <= sp.last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_pixel(sp);
        splats_sent++;
        @(negedge aclk);
    endtask

    // splat centred within a few pixels of (px, py) with a modest conic
    function automatic splat_t near_splat(logic [11:0] px, logic [11:0] py, bit last);
        splat_t sp;
        sp.px      = px;
        sp.py      = py;
        sp.cx      = 21'({px, 8'd128}) + $signed(21'($urandom_range(0, 2048)) - 21'sd1024);
        sp.cy      = 21'({py, 8'd128}) + $signed(21'($urandom_range(0, 2048)) - 21'sd1024);
        sp.cxx     = $urandom_range(0, 32'h0200_0000);
        sp.cyy     = $urandom_range(0, 32'h0200_0000);
        sp.cxy     = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        sp.opacity = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(60000, 65535))
                                                 : 16'($urandom);
        sp.red     = 16'($urandom);
        sp.green   = 16'($urandom);
        sp.blue    = 16'($urandom);
        sp.last    = last;
        return sp;
    endfunction

    function automatic splat_t noise_splat();
        splat_t sp;
        sp.px      = 12'($urandom);
        sp.py      = 12'($urandom);
        sp.cx      = 21'($urandom);
        sp.cy      = 21'($urandom);
        sp.cxx     = $urandom;
        sp.cxy     = $urandom;
        sp.cyy     = $urandom;
        sp.opacity = 16'($urandom);
        sp.red     = 16'($urandom);
        sp.green   = 16'($urandom);
        sp.blue    = 16'($urandom);
        sp.last    = ($urandom_range(0, 3) == 0);
        return sp;
    endfunction

    task automatic send_pixel(int count);
        logic [11:0] px, py;
        px = 12'($urandom_range(0, 4088));
        py = 12'($urandom_range(0, 4088));
        for (int i = 0; i < count; i++) begin
            send_splat(near_splat(px, py, i == count - 1));
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic test_directed();
        splat_t sp;
        // empty pixel as one zero-opacity item
        sp = near_splat(12'd0, 12'd0, 1'b1);
        sp.opacity = 16'd0;
        send_splat(sp);
        // centre at the range limit, zero conic, full opacity and colour: saturates transmittance
        sp = near_splat(12'd4095, 12'd4095, 1'b0);
        sp.cx = 21'sh0FFFFF;
        sp.cy = 21'sh0FFFFF;
        sp.cxx = 0;
        sp.cxy = 0;
        sp.cyy = 0;
        sp.opacity = 16'hFFFF;
        sp.red = 16'hFFFF;
        sp.green = 16'hFFFF;
        sp.blue = 16'hFFFF;
        repeat (4) send_splat(sp);
        sp.last = 1'b1;
        send_splat(sp);
        // negative conic gives a positive exponent
        sp = near_splat(12'd100, 12'd200, 1'b0);
        sp.cxx = 32'sh8000_0000;
        sp.cyy = 32'sh8000_0000;
        send_splat(sp);
        // far tail
        sp = near_splat(12'd100, 12'd200, 1'b0);
        sp.cx = -21'sd1048576;
        sp.cxx = 32'sh7FFF_FFFF;
        send_splat(sp);
        // faint splat
        sp = near_splat(12'd100, 12'd200, 1'b0);
        sp.opacity = 16'd200;
        send_splat(sp);
        // mixed coordinates within one pixel, with an extreme cross term
        sp = near_splat(12'd7, 12'd9, 1'b0);
        sp.cxy = 32'sh8000_0000;
        send_splat(sp);
        sp = near_splat(12'd2048, 12'd1, 1'b1);
        sp.cxy = 32'sh7FFF_FFFF;
        send_splat(sp);
        for (int i = 0; i < 6; i++) begin
            send_splat(noise_splat());
        end
        sp = near_splat(12'd3, 12'd3, 1'b1);
        send_splat(sp);
        drain();
    endtask

    task automatic test_backpressure();
        hold_request = 500;
        for (int i = 0; i < 8; i++) begin
            send_pixel($urandom_range(3, 6));
        end
        drain();
    endtask

    task automatic test_no_gaps();
        idle_pct = 0;
        for (int i = 0; i < 25; i++) begin
            send_pixel($urandom_range(1, 5));
        end
        idle_pct = 35;
        drain();
    endtask

    task automatic test_random();
        while (splats_sent < 950) begin
            if ($urandom_range(0, 99) < 15) begin
                send_splat(noise_splat());
            end else begin
                send_pixel($urandom_range(1, 8));
            end
        end
        send_splat(near_splat(12'd5, 12'd5, 1'b1));
        drain();
    endtask

    initial begin
        for (int k = 0; k < TABLE_SIZE; k++) begin
            weight_lut[k] = weight_at(k);
        end
        clear_pixel();
        mismatches    = 0;
        splats_sent   = 0;
        idle_pct      = 35;
        hold_request  = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_pixel_x     = '0;
        s_pixel_y     = '0;
        s_center_x    = '0;
        s_center_y    = '0;
        s_conic_xx    = '0;
        s_conic_xy    = '0;
        s_conic_yy    = '0;
        s_opacity     = '0;
        s_color_red   = '0;
        s_color_green = '0;
        s_color_blue  = '0;
        s_last_splat  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_no_gaps();
        test_random();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        pixel_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected transfer: x=%0d y=%0d", m_out_x, m_out_y);
                end
            end else begin
                e = pending_pixels.pop_front();
                if (e.x !== m_out_x || e.y !== m_out_y || e.red !== m_pixel_red
                        || e.green !== m_pixel_green || e.blue !== m_pixel_blue) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected x=%0d y=%0d rgb=%0d,%0d,%0d",
                                 e.x, e.y, e.red, e.green, e.blue);
                        $display("          actual   x=%0d y=%0d rgb=%0d,%0d,%0d",
                                 m_out_x, m_out_y, m_pixel_red, m_pixel_green,
                                 m_pixel_blue);
                    end
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
